>>> rtl/cdsr_pkg.sv
// package for the clock and data serial receiver
// holds item type, register indexes and reset constants; no dependencies

package cdsr_pkg;

  localparam int unsigned MaxBitsDefault  = 64;
  localparam int unsigned TimeBitsDefault = 32;

  localparam int unsigned PeriodW  = 16;
  localparam int unsigned CountW   = 7;
  localparam int unsigned FrameW   = 64;
  localparam int unsigned StampW   = 32;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [PeriodW-1:0] MinPeriodReset = 16'd400;
  localparam logic [PeriodW-1:0] MaxPeriodReset = 16'd1600;

  localparam logic [CfgIdxW-1:0] CfgEnable    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMinPeriod = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxPeriod = 2'd2;

  typedef struct packed {
    logic clock_level;
    logic data_level;
    logic noise_clear;
  } item_t;

endpackage

>>> rtl/cdsr_in_stage.sv
// input register of the clock and data serial receiver
// depends on cdsr_pkg for the item type

module cdsr_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cdsr_pkg::item_t item_i,
  output logic           item_valid_o,
  input  logic           item_ready_i,
  output cdsr_pkg::item_t item_o
);
  import cdsr_pkg::*;

  logic  valid_q;
  item_t item_q;
  logic  take;

  assign take         = valid_q & item_ready_i;
  assign in_ready_o   = ~valid_q | take;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

>>> rtl/cdsr_core.sv
// frame state, configuration registers and result register
// depends on cdsr_pkg for the item type, constants and register indexes

module cdsr_core #(
  parameter int unsigned MAX_BITS  = cdsr_pkg::MaxBitsDefault,
  parameter int unsigned TIME_BITS = cdsr_pkg::TimeBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cdsr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cdsr_pkg::PeriodW-1:0]  cfg_data_i,
  input  logic                          item_valid_i,
  output logic                          item_ready_o,
  input  cdsr_pkg::item_t               item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          frame_ready_o,
  output logic [cdsr_pkg::CountW-1:0]   bits_received_o,
  output logic [cdsr_pkg::FrameW-1:0]   frame_bits_o,
  output logic                          noise_seen_o,
  output logic [cdsr_pkg::StampW-1:0]   last_edge_time_o
);
  import cdsr_pkg::*;

  localparam int unsigned WideW = (TIME_BITS > StampW) ? TIME_BITS : StampW;
  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_BITS);

  logic                 enable_q;
  logic [PeriodW-1:0]   min_q, max_q;
  logic                 prev_q;
  logic [FrameW-1:0]    shift_q, shift_d;
  logic [CountW-1:0]    count_q, count_d;
  logic                 noise_q, noise_d;
  logic [TIME_BITS-1:0] edge_q, edge_d;
  logic [TIME_BITS-1:0] time_q;

  logic                 out_valid_q;
  logic                 ready_res_q;
  logic [CountW-1:0]    count_res_q;
  logic [FrameW-1:0]    shift_res_q;
  logic                 noise_res_q;
  logic [StampW-1:0]    stamp_res_q;

  logic                 fire, cfg_we, rising, too_fast, too_slow;
  logic [TIME_BITS-1:0] gap_now, gap_after;
  logic [FrameW-1:0]    base_shift;
  logic [CountW-1:0]    base_count;
  logic [WideW-1:0]     edge_wide;

  assign cfg_ready_o  = 1'b1;
  assign cfg_we       = cfg_valid_i & cfg_ready_o;
  assign item_ready_o = ~out_valid_q | out_ready_i;
  assign fire         = item_valid_i & item_ready_o;

  assign rising   = item_i.clock_level & ~prev_q;
  assign gap_now  = time_q - edge_q;
  assign too_fast = (count_q != '0) && (gap_now < TIME_BITS'(min_q));
  assign too_slow = (count_q != '0) && (gap_now > TIME_BITS'(max_q));

  always_comb begin
    shift_d    = shift_q;
    count_d    = count_q;
    noise_d    = noise_q;
    edge_d     = edge_q;
    base_shift = too_slow ? '0 : shift_q;
    base_count = too_slow ? '0 : count_q;
    if (enable_q && rising) begin
      if (too_fast) begin
        noise_d = 1'b1;
        shift_d = '0;
        count_d = '0;
      end else begin
        edge_d  = time_q;
        shift_d = base_shift;
        count_d = base_count;
        if (base_count < MaxCount) begin
          shift_d = {base_shift[FrameW-2:0], ~item_i.data_level};
          count_d = base_count + 1'b1;
        end
      end
    end
  end

  assign gap_after = time_q - edge_d;
  assign edge_wide = WideW'(edge_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      min_q    <= MinPeriodReset;
      max_q    <= MaxPeriodReset;
      prev_q   <= 1'b0;
      shift_q  <= '0;
      count_q  <= '0;
      noise_q  <= 1'b0;
      edge_q   <= '0;
      time_q   <= '0;
    end else begin
      if (fire) begin
        prev_q  <= item_i.clock_level;
        shift_q <= shift_d;
        count_q <= count_d;
        noise_q <= noise_d & ~item_i.noise_clear;
        edge_q  <= edge_d;
        time_q  <= time_q + 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index_i)
          CfgEnable: begin
            enable_q <= cfg_data_i[0];
            if (cfg_data_i[0]) begin
              shift_q <= '0;
              count_q <= '0;
              noise_q <= 1'b0;
            end
          end
          CfgMinPeriod: min_q <= cfg_data_i;
          CfgMaxPeriod: max_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (item_ready_o) begin
      out_valid_q <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      ready_res_q <= enable_q & (gap_after > TIME_BITS'(max_q));
      count_res_q <= count_d;
      shift_res_q <= shift_d;
      noise_res_q <= noise_d;
      stamp_res_q <= edge_wide[StampW-1:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_ready_o    = ready_res_q;
  assign bits_received_o  = count_res_q;
  assign frame_bits_o     = shift_res_q;
  assign noise_seen_o     = noise_res_q;
  assign last_edge_time_o = stamp_res_q;

endmodule

>>> rtl/clock_data_serial_receiver.sv
// Clock and data serial receiver. Takes one sample of the clock and data lines per
// request and returns one result per request, one request per cycle sustained unless the
// result is stalled by out_ready_i. A request passes the input register and then the
// interval subtract, compare and shift in the core into the result register. Configuration
// writes are taken every cycle; enabling clears the frame and the noise flag.
// depends on cdsr_pkg, cdsr_in_stage and cdsr_core

module clock_data_serial_receiver #(
  parameter int unsigned MAX_BITS  = cdsr_pkg::MaxBitsDefault,
  parameter int unsigned TIME_BITS = cdsr_pkg::TimeBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cdsr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cdsr_pkg::PeriodW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          clock_level_i,
  input  logic                          data_level_i,
  input  logic                          noise_clear_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          frame_ready_o,
  output logic [cdsr_pkg::CountW-1:0]   bits_received_o,
  output logic [cdsr_pkg::FrameW-1:0]   frame_bits_o,
  output logic                          noise_seen_o,
  output logic [cdsr_pkg::StampW-1:0]   last_edge_time_o
);
  import cdsr_pkg::*;

  item_t item_in, item_reg;
  logic  item_valid, item_ready;

  assign item_in.clock_level = clock_level_i;
  assign item_in.data_level  = data_level_i;
  assign item_in.noise_clear = noise_clear_i;

  cdsr_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (item_in),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item_reg)
  );

  cdsr_core #(
    .MAX_BITS  (MAX_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .item_valid_i     (item_valid),
    .item_ready_o     (item_ready),
    .item_i           (item_reg),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_ready_o    (frame_ready_o),
    .bits_received_o  (bits_received_o),
    .frame_bits_o     (frame_bits_o),
    .noise_seen_o     (noise_seen_o),
    .last_edge_time_o (last_edge_time_o)
  );

endmodule

>>> rtl/cdsr_checker.sv
// port-level checks for the clock and data serial receiver
// depends on cdsr_pkg; bound to clock_data_serial_receiver at the end of this file

module cdsr_checker #(
  parameter int unsigned MAX_BITS = cdsr_pkg::MaxBitsDefault
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [cdsr_pkg::CountW-1:0]   bits_received_o,
  input logic [cdsr_pkg::FrameW-1:0]   frame_bits_o,
  input logic                          noise_seen_o,
  input logic [cdsr_pkg::StampW-1:0]   last_edge_time_o
);
  import cdsr_pkg::*;

  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_BITS);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_bits_o)
      && $stable(bits_received_o) && $stable(noise_seen_o) && $stable(last_edge_time_o))
    else $error("result changed while stalled");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bits_received_o <= MaxCount)
    else $error("bit count above limit");

  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bits_received_o == '0 |-> frame_bits_o == '0)
    else $error("bits held in an empty frame");

  // input only stalls behind a waiting result
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a pending result");

endmodule

bind clock_data_serial_receiver cdsr_checker #(
  .MAX_BITS (MAX_BITS)
) u_cdsr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .bits_received_o  (bits_received_o),
  .frame_bits_o     (frame_bits_o),
  .noise_seen_o     (noise_seen_o),
  .last_edge_time_o (last_edge_time_o)
);

>>> tb/tb.sv
// self-checking testbench for clock_data_serial_receiver: predicts every status
// result from the line samples and register writes, with random valid and ready gaps
// depends on cdsr_pkg and the receiver rtl

`timescale 1ns / 1ps

module tb;
  import cdsr_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned ErrorPrintCap = 40;

  typedef struct packed {
    logic                frame_ready;
    logic [CountW-1:0]   bits_received;
    logic [FrameW-1:0]   frame_bits;
    logic                noise_seen;
    logic [StampW-1:0]   last_edge_time;
  } rx_status_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgEnable;
  logic [PeriodW-1:0]  cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                clock_level_i = 1'b0;
  logic                data_level_i = 1'b0;
  logic                noise_clear_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                frame_ready_o;
  logic [CountW-1:0]   bits_received_o;
  logic [FrameW-1:0]   frame_bits_o;
  logic                noise_seen_o;
  logic [StampW-1:0]   last_edge_time_o;

  clock_data_serial_receiver dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .clock_level_i    (clock_level_i),
    .data_level_i     (data_level_i),
    .noise_clear_i    (noise_clear_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_ready_o    (frame_ready_o),
    .bits_received_o  (bits_received_o),
    .frame_bits_o     (frame_bits_o),
    .noise_seen_o     (noise_seen_o),
    .last_edge_time_o (last_edge_time_o)
  );

  always #10 clk_i = ~clk_i;

  // receiver state mirror
  logic                rx_on = 1'b0;
  logic [PeriodW-1:0]  min_gap = MinPeriodReset;
  logic [PeriodW-1:0]  max_gap = MaxPeriodReset;
  logic                prev_clock = 1'b0;
  logic [FrameW-1:0]   shift_reg = '0;
  logic [CountW-1:0]   bit_count = '0;
  logic                noise = 1'b0;
  logic [31:0]         edge_us = '0;
  logic [31:0]         now_us = '0;

  item_t      pending_samples[$];
  rx_status_t expected_status[$];
  item_t      sent_item;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  bit          send_steady = 1'b0;
  bit          recv_steady = 1'b0;
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned samples_queued = 0;

  function automatic rx_status_t decode_sample(item_t s);
    rx_status_t r;
    logic [31:0] gap;
    logic        take;
    take = 1'b1;
    if (rx_on && s.clock_level && !prev_clock) begin
      if (bit_count != '0) begin
        gap = now_us - edge_us;
        if (gap < min_gap) begin
          noise = 1'b1;
          shift_reg = '0;
          bit_count = '0;
          take = 1'b0;
        end else if (gap > max_gap) begin
          shift_reg = '0;
          bit_count = '0;
        end
      end
      if (take) begin
        edge_us = now_us;
        if (bit_count < MaxBitsDefault) begin
          shift_reg = {shift_reg[FrameW-2:0], ~s.data_level};
          bit_count = bit_count + 1'b1;
        end
      end
    end
    prev_clock = s.clock_level;
    gap = now_us - edge_us;
    r.frame_ready = rx_on && (gap > max_gap);
    r.bits_received = bit_count;
    r.frame_bits = shift_reg;
    r.noise_seen = noise;
    r.last_edge_time = edge_us;
    if (s.noise_clear) noise = 1'b0;
    now_us = now_us + 1;
    return r;
  endfunction

  function automatic int unsigned pick_wait(bit steady);
    return steady ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic report_error(string msg);
    error_count++;
    if (error_count <= ErrorPrintCap) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) expected_status.push_back(decode_sample(sent_item));
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          sent_item = pending_samples.pop_front();
          in_valid_i <= 1'b1;
          clock_level_i <= sent_item.clock_level;
          data_level_i <= sent_item.data_level;
          noise_clear_i <= sent_item.noise_clear;
          send_gap = pick_wait(send_steady);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver side
  always @(posedge clk_i or negedge rst_ni) begin
    rx_status_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_status.size() == 0) begin
          report_error("status result with no request outstanding");
        end else begin
          want = expected_status.pop_front();
          check_field("frame_ready", frame_ready_o, want.frame_ready);
          check_field("bits_received", bits_received_o, want.bits_received);
          check_field("frame_bits", frame_bits_o, want.frame_bits);
          check_field("noise_seen", noise_seen_o, want.noise_seen);
          check_field("last_edge_time", last_edge_time_o, want.last_edge_time);
        end
        recv_stall = pick_wait(recv_steady);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [PeriodW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgEnable: begin
        rx_on = value[0];
        if (value[0]) begin
          shift_reg = '0;
          bit_count = '0;
          noise = 1'b0;
        end
      end
      CfgMinPeriod: min_gap = value;
      CfgMaxPeriod: max_gap = value;
      default: ;
    endcase
  endtask

  task automatic queue_sample(bit clk, bit dat, bit clr);
    item_t s;
    s.clock_level = clk;
    s.data_level = dat;
    s.noise_clear = clr;
    pending_samples.push_back(s);
    samples_queued++;
  endtask

  // gap-1 low samples then the rising one
  task automatic queue_edge(int unsigned gap, bit dat);
    for (int i = 1; i < gap; i++) queue_sample(1'b0, $urandom_range(0, 1), $urandom_range(0, 7) == 0);
    queue_sample(1'b1, dat, $urandom_range(0, 7) == 0);
  endtask

  task automatic drain;
    do @(posedge clk_i);
    while (pending_samples.size() != 0 || in_valid_i || expected_status.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned lim;
    lim = (max_gap >= 16) ? 4 : max_gap + 3;
    return $urandom_range(2, lim);
  endfunction

  initial begin
    int unsigned goal;
    int unsigned phase_len;
    int unsigned start;
    int unsigned pick;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // disabled after reset, ends with the clock held high
    send_steady = 1'b1;
    queue_sample(1'b0, 1'b0, 1'b0);
    queue_sample(1'b1, 1'b0, 1'b1);
    queue_sample(1'b0, 1'b1, 1'b0);
    queue_sample(1'b1, 1'b1, 1'b1);
    drain();

    // tight window; enabling with the clock high gives no edge
    write_reg(CfgMinPeriod, 16'd3);
    write_reg(CfgMaxPeriod, 16'd6);
    write_reg(CfgEnable, 16'd1);
    send_steady = 1'b0;
    queue_sample(1'b1, 1'b0, 1'b0);
    queue_edge(2, 1'b0);
    queue_edge(4, 1'b1);
    queue_edge(2, 1'b0);
    queue_edge(3, 1'b0);
    queue_sample(1'b0, 1'b1, 1'b1);
    queue_sample(1'b0, 1'b1, 1'b0);
    queue_sample(1'b1, 1'b1, 1'b0);
    queue_edge(6, 1'b1);
    queue_edge(7, 1'b0);
    repeat (9) queue_sample(1'b0, 1'b0, 1'b0);
    drain();

    // full frame and dropped bits
    write_reg(CfgMinPeriod, 16'd0);
    write_reg(CfgMaxPeriod, 16'hFFFF);
    write_reg(CfgEnable, 16'd1);
    recv_steady = 1'b1;
    repeat (70) queue_edge(2, $urandom_range(0, 1));
    drain();

    // disabled keeps state and ignores edges
    write_reg(CfgEnable, 16'hFFFE);
    recv_steady = 1'b0;
    repeat (3) queue_edge(2, 1'b0);
    drain();
    write_reg(CfgMaxPeriod, 16'd0);
    write_reg(CfgEnable, 16'd1);
    queue_sample(1'b1, 1'b0, 1'b0);
    repeat (3) queue_edge(2, 1'b1);
    drain();

    goal = 850;
    while (samples_queued < goal) begin
      send_steady = ($urandom_range(0, 3) == 0);
      recv_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 7);
        write_reg(CfgMinPeriod, pick == 0 ? 16'd0 : pick == 1 ? 16'hFFFF :
                  pick == 2 ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(1, 4)));
      end
      if ($urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 7);
        write_reg(CfgMaxPeriod, pick == 0 ? 16'd0 : pick == 1 ? 16'hFFFF :
                  pick == 2 ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(3, 12)));
      end
      if ($urandom_range(0, 3) != 0)
        write_reg(CfgEnable, {15'($urandom_range(0, 32767)), $urandom_range(0, 5) != 0});
      phase_len = $urandom_range(40, 90);
      start = samples_queued;
      while (samples_queued - start < phase_len) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          queue_edge(pick_gap(), $urandom_range(0, 1));
        end else if (pick < 9) begin
          queue_sample($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 3) == 0);
        end else begin
          repeat ($urandom_range(1, 16)) queue_sample(1'b0, $urandom_range(0, 1), 1'b0);
        end
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/cdsr_pkg.sv
rtl/cdsr_in_stage.sv
rtl/cdsr_core.sv
rtl/clock_data_serial_receiver.sv
rtl/cdsr_checker.sv
tb/tb.sv
